/* rtl/core/clns_pkg.sv */
// types, codes and constants shared by the char lcd nibble sequencer
// no dependencies

package clns_pkg;

    localparam int MAX_DIGITS = 5;
    localparam int BCD_DIGITS = 5;
    localparam int NUM_W      = 16;
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int CONV_W     = $clog2(NUM_W + 1);

    localparam logic [1:0] CMD_INIT = 2'd0;
    localparam logic [1:0] CMD_CHAR = 2'd1;
    localparam logic [1:0] CMD_NUM  = 2'd2;

    localparam logic CFG_LINE3 = 1'b0;
    localparam logic CFG_LINE4 = 1'b1;

    localparam logic [2:0] WAIT_NONE   = 3'd0;
    localparam logic [2:0] WAIT_SHORT1 = 3'd1;
    localparam logic [2:0] WAIT_SHORT2 = 3'd2;
    localparam logic [2:0] WAIT_2MS    = 3'd3;
    localparam logic [2:0] WAIT_10MS   = 3'd4;

    localparam logic [6:0] LINE2_BASE  = 7'h40;
    localparam logic [6:0] LINE3_RESET = 7'd20;
    localparam logic [6:0] LINE4_RESET = 7'd84;
    localparam logic       INS_CURSOR  = 1'b1;
    localparam logic [3:0] ASCII_DIGIT = 4'h3;

    localparam logic [3:0] INIT_LAST = 4'd13;
    localparam logic [3:0] CHAR_LAST = 4'd3;

    typedef struct packed {
        logic [1:0]       command;
        logic [2:0]       line;
        logic [5:0]       column;
        logic [7:0]       char_code;
        logic [NUM_W-1:0] number;
        logic [3:0]       digit_count;
    } t_in;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic [2:0] wait_class;
        logic       power_up_wait;
        logic       backlight;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       cursor;
        logic [7:0]       chr;
        logic [BCD_W-1:0] bcd;
        logic [2:0]       dcnt;
        logic [3:0]       last_idx;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [3:0] nibble;
        logic [2:0] wait_class;
        logic       power_up_wait;
    } t_init_ent;

    function automatic t_init_ent init_entry(input logic [3:0] idx);
        t_init_ent e;
        e.power_up_wait = 1'b0;
        case (idx)
            4'd0: begin
                e.nibble = 4'h3; e.wait_class = WAIT_10MS; e.power_up_wait = 1'b1;
            end
            4'd1:  begin e.nibble = 4'h3; e.wait_class = WAIT_SHORT2; end
            4'd2:  begin e.nibble = 4'h3; e.wait_class = WAIT_SHORT1; end
            4'd3:  begin e.nibble = 4'h2; e.wait_class = WAIT_SHORT1; end
            4'd4:  begin e.nibble = 4'h2; e.wait_class = WAIT_NONE;   end
            4'd5:  begin e.nibble = 4'h8; e.wait_class = WAIT_SHORT1; end
            4'd6:  begin e.nibble = 4'h0; e.wait_class = WAIT_NONE;   end
            4'd7:  begin e.nibble = 4'h8; e.wait_class = WAIT_SHORT1; end
            4'd8:  begin e.nibble = 4'h0; e.wait_class = WAIT_NONE;   end
            4'd9:  begin e.nibble = 4'h1; e.wait_class = WAIT_2MS;    end
            4'd10: begin e.nibble = 4'h0; e.wait_class = WAIT_NONE;   end
            4'd11: begin e.nibble = 4'h6; e.wait_class = WAIT_SHORT1; end
            4'd12: begin e.nibble = 4'h0; e.wait_class = WAIT_NONE;   end
            4'd13: begin e.nibble = 4'hC; e.wait_class = WAIT_SHORT1; end
            default: begin e.nibble = 4'h0; e.wait_class = WAIT_NONE; end
        endcase
        return e;
    endfunction

endpackage

/* rtl/core/clns_front.sv */
// front end: config registers, command accept, cursor address and
// binary to bcd conversion; pushes jobs into the queue; uses clns_pkg

module clns_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [6:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  clns_pkg::t_in     i_in,
    input  clns_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output clns_pkg::t_job    o_push_job
);

    logic [6:0]                    r_line3;
    logic [6:0]                    r_line4;
    logic                          r_hold;
    logic [clns_pkg::CONV_W-1:0]   r_cnt;
    logic [clns_pkg::CONV_W-1:0]   n_cnt;
    clns_pkg::t_job                r_job;
    clns_pkg::t_job                n_job;
    logic [clns_pkg::NUM_W-1:0]    r_bin;
    logic [clns_pkg::BCD_W-1:0]    r_bcd;
    logic [clns_pkg::BCD_W-1:0]    n_bcd;
    logic [clns_pkg::BCD_W-1:0]    adj;
    logic [6:0]                    base;
    logic [2:0]                    dclamp;
    logic                          accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line3 <= clns_pkg::LINE3_RESET;
            r_line4 <= clns_pkg::LINE4_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == clns_pkg::CFG_LINE3) begin
                r_line3 <= i_cfg_data;
            end else begin
                r_line4 <= i_cfg_data;
            end
        end
    end

    assign o_push     = r_hold && (r_cnt == '0) && !i_q_stat.full;
    assign o_in_ready = !r_hold || o_push;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_push_job     = r_job;
        o_push_job.bcd = r_bcd;
    end

    always_comb begin
        case (i_in.line)
            3'd2:    base = clns_pkg::LINE2_BASE;
            3'd3:    base = r_line3;
            3'd4:    base = r_line4;
            default: base = 7'd0;
        endcase
        if (i_in.digit_count > 4'(clns_pkg::MAX_DIGITS)) begin
            dclamp = 3'(clns_pkg::MAX_DIGITS);
        end else begin
            dclamp = i_in.digit_count[2:0];
        end
        n_job.kind   = i_in.command;
        n_job.cursor = {clns_pkg::INS_CURSOR, 7'(base + {1'b0, i_in.column})};
        n_job.chr    = i_in.char_code;
        n_job.bcd    = '0;
        n_job.dcnt   = dclamp;
        case (i_in.command)
            clns_pkg::CMD_INIT: n_job.last_idx = clns_pkg::INIT_LAST;
            clns_pkg::CMD_CHAR: n_job.last_idx = clns_pkg::CHAR_LAST;
            default:            n_job.last_idx = {dclamp, 1'b1};
        endcase
        n_cnt = (i_in.command == clns_pkg::CMD_NUM) ? clns_pkg::CONV_W'(clns_pkg::NUM_W) : '0;
    end

    // add 3 to every bcd digit of 5 or more, then shift in the next binary bit
    always_comb begin
        for (int d = 0; d < clns_pkg::BCD_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
        n_bcd = {adj[clns_pkg::BCD_W-2:0], r_bin[clns_pkg::NUM_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (accept) begin
                r_hold <= (i_in.command == clns_pkg::CMD_INIT)
                       || (i_in.command == clns_pkg::CMD_CHAR)
                       || (i_in.command == clns_pkg::CMD_NUM);
                r_cnt  <= n_cnt;
            end else begin
                if (o_push) begin
                    r_hold <= 1'b0;
                end
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
            r_bin <= i_in.number;
            r_bcd <= '0;
        end else if (r_cnt != '0) begin
            r_bin <= {r_bin[clns_pkg::NUM_W-2:0], 1'b0};
            r_bcd <= n_bcd;
        end
    end

endmodule

/* rtl/core/clns_queue.sv */
// two-entry job queue between front end and sequencer
// uses clns_pkg

module clns_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  clns_pkg::t_job    i_push_job,
    input  logic              i_pop,
    output clns_pkg::t_job    o_head,
    output clns_pkg::t_q_stat o_stat
);

    clns_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_count;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

/* rtl/core/clns_back.sv */
// sequencer: walks one job's transfer list into the output register
// uses clns_pkg

module clns_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clns_pkg::t_job    i_head,
    input  clns_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output clns_pkg::t_out    o_out
);

    logic                r_active;
    logic [3:0]          r_idx;
    clns_pkg::t_job      r_job;
    logic                r_bl;
    logic                r_out_valid;
    clns_pkg::t_out      r_out;
    clns_pkg::t_out      n_out;
    clns_pkg::t_init_ent ient;
    logic [3:0]          didx;
    logic [2:0]          dpos;
    logic [3:0]          digit;
    logic [7:0]          dbyte;
    logic                emit;

    assign didx = r_idx - 4'd2;
    assign dpos = r_job.dcnt - 3'd1 - didx[3:1];

    always_comb begin
        case (dpos)
            3'd0:    digit = r_job.bcd[3:0];
            3'd1:    digit = r_job.bcd[7:4];
            3'd2:    digit = r_job.bcd[11:8];
            3'd3:    digit = r_job.bcd[15:12];
            3'd4:    digit = r_job.bcd[19:16];
            default: digit = 4'd0;
        endcase
        dbyte = (r_job.kind == clns_pkg::CMD_CHAR) ? r_job.chr : {clns_pkg::ASCII_DIGIT, digit};
    end

    always_comb begin
        ient                = clns_pkg::init_entry(r_idx);
        n_out.backlight     = r_bl;
        n_out.last          = (r_idx == r_job.last_idx);
        n_out.power_up_wait = 1'b0;
        n_out.reg_select    = 1'b0;
        n_out.wait_class    = clns_pkg::WAIT_NONE;
        if (r_job.kind == clns_pkg::CMD_INIT) begin
            n_out.nibble        = ient.nibble;
            n_out.wait_class    = ient.wait_class;
            n_out.power_up_wait = ient.power_up_wait;
        end else if (r_idx == 4'd0) begin
            n_out.nibble = r_job.cursor[7:4];
        end else if (r_idx == 4'd1) begin
            n_out.nibble = r_job.cursor[3:0];
        end else begin
            n_out.reg_select = 1'b1;
            if (!r_idx[0]) begin
                n_out.nibble = dbyte[7:4];
            end else begin
                n_out.nibble = dbyte[3:0];
                if (r_job.kind == clns_pkg::CMD_NUM) begin
                    n_out.wait_class = clns_pkg::WAIT_SHORT1;
                end
            end
        end
    end

    assign emit  = r_active && (!r_out_valid || i_out_ready);
    assign o_pop = !i_q_stat.empty && (!r_active || (emit && n_out.last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= 4'd0;
            r_bl        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                r_idx       <= r_idx + 4'd1;
                if (n_out.last) begin
                    r_active <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_active <= 1'b1;
                r_idx    <= 4'd0;
                if (i_head.kind == clns_pkg::CMD_INIT) begin
                    r_bl <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* rtl/core/char_lcd_nibble_sequencer.sv */
// char lcd nibble sequencer, 4-bit bus, one command in, a run of transfers out
// throughput: one output transfer per cycle while i_out_ready is high; an item is 2 to 14
// transfers long; a number is converted to bcd in the front end, which takes no new command
// meanwhile, overlapped with earlier items through a two-entry queue
// reset: synchronous; line bases 20 and 84, backlight off, queue and output empty

module char_lcd_nibble_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_index,
    input  logic [6:0]     i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  clns_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output clns_pkg::t_out o_out
);

    logic              push;
    logic              pop;
    clns_pkg::t_job    push_job;
    clns_pkg::t_job    head;
    clns_pkg::t_q_stat q_stat;

    clns_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_job  (push_job)
    );

    clns_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_head     (head),
        .o_stat     (q_stat)
    );

    clns_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

/* rtl/core/clns_checker.sv */
// port-level checks for the char lcd nibble sequencer, bound to the top level
// uses clns_pkg

module clns_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input clns_pkg::t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output transfer changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_power_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.power_up_wait |->
            o_out.nibble == 4'h3 && o_out.backlight && !o_out.reg_select && !o_out.last)
        else $error("bad power-up transfer");

    a_long_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.power_up_wait == (o_out.wait_class == clns_pkg::WAIT_10MS)))
        else $error("10ms wait outside the first init transfer");

endmodule

bind char_lcd_nibble_sequencer clns_checker u_clns_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
